[rtl/core/pawc_pkg.sv]
`default_nettype none

package pawc_pkg;

    localparam int DEF_NUM_PAGES = 4;
    localparam int IDX_W         = 32;
    localparam int LEN_W         = 21;
    localparam int KIND_W        = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int STATUS_W      = 2;
    localparam int SLOT_OUT_W    = 2;
    localparam int BYTE_OFF_W    = 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGED        = 2'd0,
        CFG_ARRAY_SIZE   = 2'd1,
        CFG_PAGE_LENGTH  = 2'd2,
        CFG_ELEMENT_KIND = 2'd3
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_UNALLOCATED = 2'd1,
        STATUS_RANGE       = 2'd2
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT16  = 3'd0,
        KIND_INT32  = 3'd1,
        KIND_INT64  = 3'd2,
        KIND_DOUBLE = 3'd3,
        KIND_BYTE   = 3'd4
    } elem_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_PLACE,
        ST_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        RES_UNALLOC,
        RES_RANGE,
        RES_FLAT,
        RES_HIT,
        RES_MISS
    } res_kind_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [IDX_W-1:0] use_count;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
    } page_entry_t;

    typedef struct packed {
        logic hit;
        logic less;
    } match_t;

    function automatic logic [1:0] elem_shift(input logic [KIND_W-1:0] kind);
        logic [1:0] sh;
        unique case (kind)
            KIND_INT16:  sh = 2'd1;
            KIND_INT32:  sh = 2'd2;
            KIND_INT64:  sh = 2'd3;
            KIND_DOUBLE: sh = 2'd3;
            default:     sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pawc_page_store.sv]
`default_nettype none

module pawc_page_store #(
    parameter int NUM_PAGES = pawc_pkg::DEF_NUM_PAGES,
    localparam int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [SLOT_W-1:0]    rd_addr,
    output pawc_pkg::page_entry_t     rd_entry,
    input  wire logic                 wr_en,
    input  wire logic [SLOT_W-1:0]    wr_addr,
    input  wire pawc_pkg::page_entry_t wr_entry
);
    import pawc_pkg::*;

    page_entry_t          mem [NUM_PAGES];
    logic [NUM_PAGES-1:0] valid_reg;
    page_entry_t          rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A slot that was never loaded reads as all zeros.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_entry       = rd_data_reg;
            rd_entry.valid = 1'b1;
        end
        else
        begin
            rd_entry = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pawc_match.sv]
`default_nettype none

module pawc_match (
    input  wire logic [pawc_pkg::IDX_W-1:0] index,
    input  wire pawc_pkg::page_entry_t      entry,
    input  wire logic [pawc_pkg::IDX_W-1:0] least,
    input  wire logic                       first_slot,
    output pawc_pkg::match_t                result
);
    import pawc_pkg::*;

    always_comb
    begin
        result.hit  = entry.valid && (index >= entry.first) && (index <= entry.last);
        result.less = first_slot || (entry.use_count < least);
    end

endmodule

`default_nettype wire

[rtl/core/paged_array_window_cache.sv]
`default_nettype none

// Paged array window cache.
// An access transaction (action, index) enters on in_valid/in_ready and yields
// exactly one result transaction on out_valid/out_ready. Configuration writes
// arrive on cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. The user must make writes only while no access is in flight;
// the block itself does not enforce this. An access goes through a check step
// and, in paged mode, a scan of the page slots through the single read port
// of the slot store, one slot per cycle, ending early at the first hit.
// A miss adds a step for the window start, and every access ends with a step
// that registers the result and, on a hit or a miss, updates the slot store.
// The block accepts a new access in the cycle after the result is registered,
// so it takes no new access before it is through with the last one.
// A finished result waits in the output register while the next access is
// accepted and worked on; only the final update step waits for the receiver.
// Reset clears all page valid bits and restores the configuration defaults.
module paged_array_window_cache #(
    parameter int NUM_PAGES = pawc_pkg::DEF_NUM_PAGES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pawc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pawc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            action,
    input  wire logic [pawc_pkg::IDX_W-1:0]      index,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pawc_pkg::STATUS_W-1:0]        status,
    output logic                                 hit,
    output logic [pawc_pkg::SLOT_OUT_W-1:0]      slot,
    output logic [pawc_pkg::IDX_W-1:0]           element_offset,
    output logic [pawc_pkg::BYTE_OFF_W-1:0]      byte_offset,
    output logic                                 writeback,
    output logic [pawc_pkg::IDX_W-1:0]           writeback_start,
    output logic                                 load,
    output logic [pawc_pkg::IDX_W-1:0]           load_start
);
    import pawc_pkg::*;

    localparam int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int PTR_W  = SLOT_W + 1;

    logic              paged_reg;
    logic [IDX_W-1:0]  array_size_reg;
    logic [LEN_W-1:0]  page_length_reg;
    logic [KIND_W-1:0] element_kind_reg;

    state_t state_reg, state_next;

    logic              action_reg, action_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    res_kind_t         kind_reg, kind_next;
    logic              fit_reg, fit_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] eval_slot_reg, eval_slot_next;
    logic [SLOT_W-1:0] sel_slot_reg, sel_slot_next;
    page_entry_t       sel_entry_reg, sel_entry_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  hit_reg, hit_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0]      elem_off_reg, elem_off_next;
    logic [BYTE_OFF_W-1:0] byte_off_reg, byte_off_next;
    logic                  wb_reg, wb_next;
    logic [IDX_W-1:0]      wb_start_reg, wb_start_next;
    logic                  load_reg, load_next;
    logic [IDX_W-1:0]      load_start_reg, load_start_next;

    logic [LEN_W-1:0]    len_eff;
    logic [IDX_W-1:0]    len_ext;
    logic [1:0]          shift;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    page_entry_t         rd_entry;
    logic                wr_en;
    page_entry_t         wr_entry;
    match_t              match;
    logic [IDX_W:0]      end_sum;
    logic [IDX_W-1:0]    offset;
    logic [SLOT_W+1:0]   slot_ext;
    logic                out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assign status          = status_reg;
    assign hit             = hit_reg;
    assign slot            = slot_reg;
    assign element_offset  = elem_off_reg;
    assign byte_offset     = byte_off_reg;
    assign writeback       = wb_reg;
    assign writeback_start = wb_start_reg;
    assign load            = load_reg;
    assign load_start      = load_start_reg;

    assign len_eff  = (page_length_reg == '0) ? LEN_W'(1) : page_length_reg;
    assign len_ext  = {{(IDX_W-LEN_W){1'b0}}, len_eff};
    assign shift    = elem_shift(element_kind_reg);
    assign slot_ext = {2'b00, sel_slot_reg};
    assign out_free = !out_valid_reg || out_ready;

    pawc_page_store #(
        .NUM_PAGES(NUM_PAGES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_entry(rd_entry),
        .wr_en   (wr_en),
        .wr_addr (sel_slot_reg),
        .wr_entry(wr_entry)
    );

    pawc_match u_match (
        .index     (index_reg),
        .entry     (rd_entry),
        .least     (sel_entry_reg.use_count),
        .first_slot(eval_slot_reg == '0),
        .result    (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paged_reg        <= 1'b0;
            array_size_reg   <= '0;
            page_length_reg  <= LEN_W'(1);
            element_kind_reg <= KIND_INT16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PAGED:        paged_reg        <= cfg_data[0];
                CFG_ARRAY_SIZE:   array_size_reg   <= cfg_data[IDX_W-1:0];
                CFG_PAGE_LENGTH:  page_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_ELEMENT_KIND: element_kind_reg <= cfg_data[KIND_W-1:0];
                default:          paged_reg        <= paged_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        index_reg      <= index_next;
        kind_reg       <= kind_next;
        fit_reg        <= fit_next;
        tail_reg       <= tail_next;
        start_reg      <= start_next;
        ptr_reg        <= ptr_next;
        eval_slot_reg  <= eval_slot_next;
        sel_slot_reg   <= sel_slot_next;
        sel_entry_reg  <= sel_entry_next;
        status_reg     <= status_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        elem_off_reg   <= elem_off_next;
        byte_off_reg   <= byte_off_next;
        wb_reg         <= wb_next;
        wb_start_reg   <= wb_start_next;
        load_reg       <= load_next;
        load_start_reg <= load_start_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        index_next      = index_reg;
        kind_next       = kind_reg;
        fit_next        = fit_reg;
        tail_next       = tail_reg;
        start_next      = start_reg;
        ptr_next        = ptr_reg;
        pend_next       = 1'b0;
        eval_slot_next  = eval_slot_reg;
        sel_slot_next   = sel_slot_reg;
        sel_entry_next  = sel_entry_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        elem_off_next   = elem_off_reg;
        byte_off_next   = byte_off_reg;
        wb_next         = wb_reg;
        wb_start_next   = wb_start_reg;
        load_next       = load_reg;
        load_start_next = load_start_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[SLOT_W-1:0];
        wr_en           = 1'b0;
        wr_entry        = sel_entry_reg;
        end_sum         = {1'b0, index_reg} + {1'b0, len_ext};
        offset          = index_reg - ((kind_reg == RES_MISS) ? start_reg
                                                              : sel_entry_reg.first);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    index_next  = index;
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                fit_next  = (len_ext <= array_size_reg);
                tail_next = array_size_reg - len_ext;
                ptr_next  = '0;
                if (array_size_reg == '0)
                begin
                    kind_next  = RES_UNALLOC;
                    state_next = ST_COMMIT;
                end
                else if (index_reg >= array_size_reg)
                begin
                    kind_next  = RES_RANGE;
                    state_next = ST_COMMIT;
                end
                else if (!paged_reg)
                begin
                    kind_next  = RES_FLAT;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (ptr_reg < PTR_W'(NUM_PAGES))
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    eval_slot_next = ptr_reg[SLOT_W-1:0];
                    ptr_next       = ptr_reg + PTR_W'(1);
                end
                if (pend_reg)
                begin
                    if (match.hit)
                    begin
                        sel_entry_next = rd_entry;
                        sel_slot_next  = eval_slot_reg;
                        kind_next      = RES_HIT;
                        pend_next      = 1'b0;
                        state_next     = ST_COMMIT;
                    end
                    else
                    begin
                        if (match.less)
                        begin
                            sel_entry_next = rd_entry;
                            sel_slot_next  = eval_slot_reg;
                        end
                        if (eval_slot_reg == SLOT_W'(NUM_PAGES - 1))
                        begin
                            kind_next  = RES_MISS;
                            pend_next  = 1'b0;
                            state_next = ST_PLACE;
                        end
                    end
                end
            end

            ST_PLACE:
            begin
                // Near the end of the array the window is pulled back to fit.
                if (end_sum >= {1'b0, array_size_reg})
                begin
                    start_next = fit_reg ? tail_reg : '0;
                end
                else
                begin
                    start_next = index_reg;
                end
                state_next = ST_COMMIT;
            end

            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                    status_next     = STATUS_OK;
                    hit_next        = 1'b0;
                    slot_next       = '0;
                    elem_off_next   = '0;
                    byte_off_next   = '0;
                    wb_next         = 1'b0;
                    wb_start_next   = '0;
                    load_next       = 1'b0;
                    load_start_next = '0;
                    case (kind_reg)
                        RES_UNALLOC:
                        begin
                            status_next = STATUS_UNALLOCATED;
                        end
                        RES_RANGE:
                        begin
                            status_next = STATUS_RANGE;
                        end
                        RES_FLAT:
                        begin
                            elem_off_next = index_reg;
                            byte_off_next = {3'b000, index_reg} << shift;
                        end
                        RES_HIT:
                        begin
                            hit_next      = 1'b1;
                            slot_next     = slot_ext[SLOT_OUT_W-1:0];
                            elem_off_next = offset;
                            byte_off_next = {3'b000, offset} << shift;
                            wr_en         = 1'b1;
                            wr_entry.dirty = sel_entry_reg.dirty | action_reg;
                            if (sel_entry_reg.use_count != '1)
                            begin
                                wr_entry.use_count = sel_entry_reg.use_count + IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            slot_next       = slot_ext[SLOT_OUT_W-1:0];
                            elem_off_next   = offset;
                            byte_off_next   = {3'b000, offset} << shift;
                            wb_next         = sel_entry_reg.valid && sel_entry_reg.dirty;
                            wb_start_next   = (sel_entry_reg.valid && sel_entry_reg.dirty)
                                              ? sel_entry_reg.first : '0;
                            load_next       = 1'b1;
                            load_start_next = start_reg;
                            wr_en           = 1'b1;
                            wr_entry.valid     = 1'b1;
                            wr_entry.dirty     = action_reg;
                            wr_entry.use_count = '0;
                            wr_entry.first     = start_reg;
                            wr_entry.last      = start_reg + len_ext - IDX_W'(1);
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sim/pawc_result_checker.sv]
`timescale 1ns / 1ps

module pawc_result_checker #(
    parameter int NUM_PAGES = pawc_pkg::DEF_NUM_PAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [pawc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pawc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            action,
    input  logic [pawc_pkg::IDX_W-1:0]      index,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [pawc_pkg::STATUS_W-1:0]   status,
    input  logic                            hit,
    input  logic [pawc_pkg::SLOT_OUT_W-1:0] slot,
    input  logic [pawc_pkg::IDX_W-1:0]      element_offset,
    input  logic [pawc_pkg::BYTE_OFF_W-1:0] byte_offset,
    input  logic                            writeback,
    input  logic [pawc_pkg::IDX_W-1:0]      writeback_start,
    input  logic                            load,
    input  logic [pawc_pkg::IDX_W-1:0]      load_start,
    output int                              results_due,
    output int                              mismatches
);
    import pawc_pkg::*;

    typedef struct packed {
        status_t                 status;
        logic                    hit;
        logic [SLOT_OUT_W-1:0]   slot;
        logic [IDX_W-1:0]        element_offset;
        logic [BYTE_OFF_W-1:0]   byte_offset;
        logic                    writeback;
        logic [IDX_W-1:0]        writeback_start;
        logic                    load;
        logic [IDX_W-1:0]        load_start;
    } access_result_t;

    logic              cfg_paged;
    logic [IDX_W-1:0]  cfg_size;
    logic [LEN_W-1:0]  cfg_len;
    logic [KIND_W-1:0] cfg_kind;

    logic [IDX_W-1:0]  win_first [NUM_PAGES];
    logic [IDX_W-1:0]  win_last  [NUM_PAGES];
    logic [IDX_W-1:0]  win_uses  [NUM_PAGES];
    logic              win_valid [NUM_PAGES];
    logic              win_dirty [NUM_PAGES];

    access_result_t pending_results [$];
    access_result_t oldest;
    int             due_count  = 0;
    int             fail_count = 0;
    int             seen       = 0;
    int             k;

    assign results_due = due_count;
    assign mismatches  = fail_count;

    function automatic logic [BYTE_OFF_W-1:0] byte_pos(input logic [IDX_W-1:0] off);
        logic [BYTE_OFF_W-1:0] width_b;
        logic [BYTE_OFF_W-1:0] wide;
        case (cfg_kind)
            KIND_INT16:              width_b = BYTE_OFF_W'(2);
            KIND_INT32:              width_b = BYTE_OFF_W'(4);
            KIND_INT64, KIND_DOUBLE: width_b = BYTE_OFF_W'(8);
            default:                 width_b = BYTE_OFF_W'(1);
        endcase
        wide = {{(BYTE_OFF_W-IDX_W){1'b0}}, off};
        return wide * width_b;
    endfunction

    // Looks the access up among the resident windows and updates them as the block would.
    function automatic access_result_t lookup_window(input logic wr,
                                                     input logic [IDX_W-1:0] idx);
        access_result_t   r;
        logic [IDX_W:0]   span;
        logic [IDX_W+1:0] reach;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] least;
        logic [IDX_W-1:0] off;
        int               s;
        int               pick;
        bit               found;
        r = '0;
        pick = 0;
        found = 1'b0;
        span = (cfg_len == '0) ? (IDX_W+1)'(1) : (IDX_W+1)'(cfg_len);
        if (cfg_size == '0) begin
            r.status = STATUS_UNALLOCATED;
            return r;
        end
        if (idx >= cfg_size) begin
            r.status = STATUS_RANGE;
            return r;
        end
        r.status = STATUS_OK;
        if (!cfg_paged) begin
            r.element_offset = idx;
            r.byte_offset = byte_pos(idx);
            return r;
        end
        for (s = 0; s < NUM_PAGES; s++) begin
            if (!found && win_valid[s] && idx >= win_first[s] && idx <= win_last[s]) begin
                pick = s;
                found = 1'b1;
            end
        end
        if (found) begin
            if (win_uses[pick] != '1)
                win_uses[pick] = win_uses[pick] + IDX_W'(1);
            if (wr)
                win_dirty[pick] = 1'b1;
            r.hit = 1'b1;
        end
        else begin
            least = win_uses[0];
            for (s = 1; s < NUM_PAGES; s++) begin
                if (win_uses[s] < least) begin
                    least = win_uses[s];
                    pick = s;
                end
            end
            if (win_valid[pick] && win_dirty[pick]) begin
                r.writeback = 1'b1;
                r.writeback_start = win_first[pick];
            end
            reach = {2'b00, idx} + {1'b0, span};
            if (reach >= {2'b00, cfg_size})
                start = (span <= {1'b0, cfg_size}) ? cfg_size - span[IDX_W-1:0] : '0;
            else
                start = idx;
            win_first[pick] = start;
            win_last[pick]  = start + span[IDX_W-1:0] - IDX_W'(1);
            win_valid[pick] = 1'b1;
            win_dirty[pick] = wr;
            win_uses[pick]  = '0;
            r.load = 1'b1;
            r.load_start = start;
        end
        off = idx - win_first[pick];
        r.slot = pick[SLOT_OUT_W-1:0];
        r.element_offset = off;
        r.byte_offset = byte_pos(off);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                    seen, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_paged = 1'b0;
            cfg_size  = '0;
            cfg_len   = LEN_W'(1);
            cfg_kind  = KIND_INT16;
            for (k = 0; k < NUM_PAGES; k++) begin
                win_first[k] = '0;
                win_last[k]  = '0;
                win_uses[k]  = '0;
                win_valid[k] = 1'b0;
                win_dirty[k] = 1'b0;
            end
            pending_results.delete();
            due_count = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result transaction arrived with no access outstanding");
                end
                else begin
                    oldest = pending_results.pop_front();
                    check_field("status", 64'(status), 64'(oldest.status));
                    check_field("hit", 64'(hit), 64'(oldest.hit));
                    check_field("slot", 64'(slot), 64'(oldest.slot));
                    check_field("element_offset", 64'(element_offset),
                                64'(oldest.element_offset));
                    check_field("byte_offset", 64'(byte_offset),
                                64'(oldest.byte_offset));
                    check_field("writeback", 64'(writeback), 64'(oldest.writeback));
                    check_field("writeback_start", 64'(writeback_start),
                                64'(oldest.writeback_start));
                    check_field("load", 64'(load), 64'(oldest.load));
                    check_field("load_start", 64'(load_start),
                                64'(oldest.load_start));
                    seen++;
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(lookup_window(action, index));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PAGED:        cfg_paged = cfg_data[0];
                    CFG_ARRAY_SIZE:   cfg_size  = cfg_data[IDX_W-1:0];
                    CFG_PAGE_LENGTH:  cfg_len   = cfg_data[LEN_W-1:0];
                    CFG_ELEMENT_KIND: cfg_kind  = cfg_data[KIND_W-1:0];
                    default:          ;
                endcase
            end
            due_count = pending_results.size();
        end
    end

endmodule

[sim/tb_paged_array_window_cache.sv]
`timescale 1ns / 1ps

module tb_paged_array_window_cache;
    import pawc_pkg::*;

    localparam logic              ACT_READ       = 1'b0;
    localparam logic              ACT_WRITE      = 1'b1;
    localparam logic [KIND_W-1:0] KIND_UNDEFINED = 3'd7;
    localparam int                HOT_SPOTS      = 6;
    localparam int                RANDOM_PHASES  = 12;
    localparam int                PHASE_ACCESSES = 120;
    localparam int                QUIET_LIMIT    = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  action;
    logic [IDX_W-1:0]      index;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [IDX_W-1:0]      element_offset;
    logic [BYTE_OFF_W-1:0] byte_offset;
    logic                  writeback;
    logic [IDX_W-1:0]      writeback_start;
    logic                  load;
    logic [IDX_W-1:0]      load_start;
    int                    results_due;
    int                    mismatches;

    logic [IDX_W-1:0] cur_size;
    int unsigned      cur_len;
    logic [IDX_W-1:0] hot [HOT_SPOTS];
    int               stall_mode = 0;
    int               stall_left = 0;
    bit               gaps_on = 1'b0;
    int               burst_left = 0;
    int               quiet = 0;

    always #5 clk = ~clk;

    paged_array_window_cache #(
        .NUM_PAGES (DEF_NUM_PAGES)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .index           (index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .hit             (hit),
        .slot            (slot),
        .element_offset  (element_offset),
        .byte_offset     (byte_offset),
        .writeback       (writeback),
        .writeback_start (writeback_start),
        .load            (load),
        .load_start      (load_start)
    );

    pawc_result_checker #(
        .NUM_PAGES (DEF_NUM_PAGES)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .index           (index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .hit             (hit),
        .slot            (slot),
        .element_offset  (element_offset),
        .byte_offset     (byte_offset),
        .writeback       (writeback),
        .writeback_start (writeback_start),
        .load            (load),
        .load_start      (load_start),
        .results_due     (results_due),
        .mismatches      (mismatches)
    );

    // The receiver alternates between always ready, coin-flip ready and long stalls.
    always @(negedge clk) begin
        if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default:
                    if ($urandom_range(0, 9) == 0) begin
                        out_ready <= 1'b0;
                        stall_left = $urandom_range(1, 24);
                    end
                    else begin
                        out_ready <= 1'b1;
                    end
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end
        else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [IDX_W-1:0] with_junk(input logic [IDX_W-1:0] val, input int w);
        logic [IDX_W-1:0] mask;
        mask = (32'd1 << w) - 32'd1;
        return ($urandom & ~mask) | (val & mask);
    endfunction

    // Mixes out-of-range indexes, the array tail, hot windows and uniform picks.
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned      roll;
        logic [IDX_W:0]   reach;
        logic [IDX_W-1:0] back;
        roll = $urandom_range(0, 99);
        if (cur_size == '0 || roll < 6)
            return $urandom;
        if (roll < 12)
            return cur_size + $urandom_range(0, 3);
        if (roll < 20) begin
            back = $urandom_range(0, 3);
            return (back < cur_size) ? cur_size - 32'd1 - back : '0;
        end
        if (roll < 70) begin
            reach = {1'b0, hot[$urandom_range(0, HOT_SPOTS - 1)]}
                    + {1'b0, $urandom_range(0, 2 * cur_len)};
            return IDX_W'(reach % {1'b0, cur_size});
        end
        return $urandom % cur_size;
    endfunction

    task automatic send_access(input logic act, input logic [IDX_W-1:0] idx);
        in_valid <= 1'b1;
        action   <= act;
        index    <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10))
                    @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        repeat (settle)
            @(negedge clk);
    endtask

    task automatic put_reg(input cfg_index_t which, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] paged_word,
                             input logic [CFG_DATA_W-1:0] size,
                             input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CFG_DATA_W-1:0] kind_word);
        int h;
        drain(12);
        put_reg(CFG_PAGED, paged_word);
        put_reg(CFG_ARRAY_SIZE, size);
        put_reg(CFG_PAGE_LENGTH, len_word);
        put_reg(CFG_ELEMENT_KIND, kind_word);
        cfg_valid <= 1'b0;
        cur_size = size;
        cur_len = (len_word[LEN_W-1:0] == '0) ? 32'd1 : 32'(len_word[LEN_W-1:0]);
        for (h = 0; h < HOT_SPOTS; h++)
            hot[h] = (size == '0) ? '0 : $urandom % size;
    endtask

    initial begin
        int               phase;
        int               n;
        logic [IDX_W-1:0] size;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PAGED;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = ACT_READ;
        index     = '0;
        cur_size  = '0;
        cur_len   = 1;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        // Out of reset the array is unallocated.
        send_access(ACT_READ, '0);
        send_access(ACT_WRITE, '1);

        configure(32'd0, 32'hFFFF_FFFF, 32'd1, 32'(KIND_INT64));
        send_access(ACT_READ, 32'hFFFF_FFFE);
        send_access(ACT_WRITE, '0);
        send_access(ACT_READ, 32'hFFFF_FFFF);

        // Raise the use count of slot 0, refill slot 1 on each miss, then evict a dirty window.
        stall_mode = 2;
        configure(32'd1, 32'd100, 32'd10, 32'(KIND_INT16));
        send_access(ACT_READ, 5);
        send_access(ACT_WRITE, 7);
        send_access(ACT_READ, 95);
        send_access(ACT_READ, 50);
        send_access(ACT_READ, 20);
        send_access(ACT_WRITE, 99);
        send_access(ACT_READ, 55);
        send_access(ACT_READ, 25);
        send_access(ACT_READ, 70);
        send_access(ACT_READ, 100);

        configure(32'd1, 32'd100, 32'd200, 32'(KIND_INT32));
        send_access(ACT_WRITE, 40);
        send_access(ACT_READ, 3);

        configure(32'd1, 32'd100, 32'd0, 32'(KIND_UNDEFINED));
        send_access(ACT_READ, 60);
        send_access(ACT_WRITE, 60);

        configure(32'd1, 32'hFFFF_FFFF, 32'd1048576, 32'(KIND_BYTE));
        send_access(ACT_READ, 32'hFFFF_FFFE);
        send_access(ACT_WRITE, '0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            stall_mode = $urandom_range(0, 2);
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
            case (phase % 6)
                0: configure(with_junk(32'd1, 1), $urandom_range(1, 400),
                             with_junk($urandom_range(1, 48), LEN_W),
                             with_junk($urandom_range(0, 7), KIND_W));
                1: begin
                    size = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                       : ($urandom | 32'h8000_0000);
                    configure(with_junk(32'd1, 1), size,
                              with_junk(($urandom_range(0, 3) == 0) ? 32'h1F_FFFF
                                        : $urandom_range(1, 32'h1F_FFFF), LEN_W),
                              with_junk($urandom_range(0, 7), KIND_W));
                end
                2: begin
                    size = $urandom_range(1, 64);
                    configure(with_junk(32'd1, 1), size,
                              with_junk(size + $urandom_range(0, 100), LEN_W),
                              with_junk($urandom_range(0, 7), KIND_W));
                end
                3: configure(with_junk(32'd1, 1), $urandom_range(1, 50),
                             with_junk(32'd0, LEN_W), with_junk($urandom_range(0, 7), KIND_W));
                4: configure(with_junk(32'd0, 1), $urandom,
                             with_junk($urandom_range(0, 64), LEN_W),
                             with_junk($urandom_range(0, 7), KIND_W));
                default: configure(with_junk($urandom_range(0, 1), 1), 32'd0,
                                   with_junk($urandom_range(0, 64), LEN_W),
                                   with_junk($urandom_range(0, 7), KIND_W));
            endcase
            for (n = 0; n < PHASE_ACCESSES; n++) begin
                if ($urandom_range(0, 149) == 0)
                    drain(0);
                send_access(1'($urandom_range(0, 1)), pick_index());
            end
        end

        drain(20);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/core/pawc_pkg.sv
rtl/core/pawc_page_store.sv
rtl/core/pawc_match.sv
rtl/core/paged_array_window_cache.sv
sim/pawc_result_checker.sv
sim/tb_paged_array_window_cache.sv
